[hw/rtl/bpdc_pkg.sv]
// Package for the button press dimmer control block.
// Holds command and event codes, configuration and status structs, and the divide-by-255 helper.
// No dependencies.
`default_nettype none

package bpdc_pkg;

  localparam logic [7:0]  LEVEL_MAX  = 8'd255;
  localparam logic [7:0]  LEVEL_STEP = 8'd85;
  localparam logic [15:0] TIMER_MAX  = 16'hFFFF;

  localparam logic [9:0]  TICK_MS_RST     = 10'd25;
  localparam logic [15:0] DEBOUNCE_MS_RST = 16'd100;
  localparam logic [15:0] MEDIUM_MS_RST   = 16'd1000;
  localparam logic [15:0] LONG_MS_RST     = 16'd5000;
  localparam logic [9:0]  PERIOD_US_RST   = 10'd40;
  localparam logic [9:0]  BLINK_TICKS_RST = 10'd40;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_LEVEL = 2'd1,
    CMD_SET_ON    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_MEDIUM = 2'd2,
    EV_LONG   = 2'd3
  } press_ev_t;

  typedef enum logic [2:0] {
    REG_TICK_MS     = 3'd0,
    REG_DEBOUNCE_MS = 3'd1,
    REG_MEDIUM_MS   = 3'd2,
    REG_LONG_MS     = 3'd3,
    REG_PERIOD_US   = 3'd4,
    REG_BLINK_TICKS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  tick_ms;
    logic [15:0] debounce_ms;
    logic [15:0] medium_ms;
    logic [15:0] long_ms;
    logic [9:0]  period_us;
    logic [9:0]  blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] drive;
    logic       light_on;
    logic [7:0] level;
    logic       run_led;
    logic       status_active;
    press_ev_t  press_event;
  } stat_t;

  // x / 255 for x below 2**18: estimate, then one correction step
  function automatic logic [9:0] div255(input logic [17:0] x);
    logic [18:0] sum;
    logic [10:0] q0;
    logic [19:0] rem;
    logic [10:0] q;
    begin
      sum = {1'b0, x} + {9'b0, x[17:8]} + 19'd1;
      q0  = sum[18:8];
      rem = {2'b00, x} - ({1'b0, q0, 8'b0} - {9'b0, q0});
      if (rem[19]) begin
        q = q0 - 11'd1;
      end else if (rem >= 20'd255) begin
        q = q0 + 11'd1;
      end else begin
        q = q0;
      end
      div255 = q[9:0];
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bpdc_ctrl.sv]
// Control state of the dimmer: debounce, press timer, press classifier, blinker, level.
// Depends on bpdc_pkg. State advances on step_en; stat shows the state after the step.
`default_nettype none

module bpdc_ctrl
  import bpdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [1:0] command,
  input  wire logic       button_raw,
  input  wire logic [7:0] value,
  input  wire cfg_t       cfg,
  output stat_t           stat
);

  logic [7:0]  level_r, level_nxt;
  logic        lamp_r, lamp_nxt;
  logic        status_r, status_nxt;
  logic        deb_r, deb_nxt;
  logic [15:0] deb_cnt_r, deb_cnt_nxt;
  logic [15:0] press_cnt_r, press_cnt_nxt;
  logic [9:0]  blink_cnt_r, blink_cnt_nxt;
  logic        blink_r, blink_nxt;
  press_ev_t   ev;

  always_comb begin
    logic [9:0]  limit;
    logic [10:0] cnt_inc;
    logic [16:0] deb_sum;
    logic [16:0] press_sum;
    logic [7:0]  quant;
    logic [7:0]  stepped;

    level_nxt     = level_r;
    lamp_nxt      = lamp_r;
    status_nxt    = status_r;
    deb_nxt       = deb_r;
    deb_cnt_nxt   = deb_cnt_r;
    press_cnt_nxt = press_cnt_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_nxt     = blink_r;
    ev            = EV_NONE;

    limit     = (cfg.blink_ticks == 10'd0) ? 10'd1 : cfg.blink_ticks;
    cnt_inc   = {1'b0, blink_cnt_r} + 11'd1;
    deb_sum   = {1'b0, deb_cnt_r} + {7'b0, cfg.tick_ms};
    press_sum = {1'b0, press_cnt_r} + {7'b0, cfg.tick_ms};

    if (level_r == LEVEL_MAX) begin
      quant = LEVEL_MAX;
    end else if (level_r >= 8'(2 * LEVEL_STEP)) begin
      quant = 8'(2 * LEVEL_STEP);
    end else if (level_r >= LEVEL_STEP) begin
      quant = LEVEL_STEP;
    end else begin
      quant = 8'd0;
    end
    stepped = (quant == LEVEL_MAX) ? 8'd0 : quant + LEVEL_STEP;

    case (command)
      CMD_TICK: begin
        if (status_r) begin
          if (blink_cnt_r == 10'd0) begin
            blink_nxt = ~blink_r;
          end
          blink_cnt_nxt = (cnt_inc >= {1'b0, limit}) ? 10'd0 : cnt_inc[9:0];
        end

        if (button_raw != deb_r) begin
          deb_cnt_nxt = deb_sum[16] ? TIMER_MAX : deb_sum[15:0];
        end else begin
          deb_cnt_nxt = 16'd0;
        end

        if (deb_r) begin
          press_cnt_nxt = press_sum[16] ? TIMER_MAX : press_sum[15:0];
        end

        if (deb_cnt_nxt > cfg.debounce_ms) begin
          deb_nxt = button_raw;
          if (!button_raw) begin
            if (press_cnt_nxt > cfg.long_ms) begin
              ev = EV_LONG;
            end else if (press_cnt_nxt > cfg.medium_ms) begin
              ev         = EV_MEDIUM;
              status_nxt = ~status_r;
            end else begin
              ev        = EV_SHORT;
              level_nxt = stepped;
              lamp_nxt  = (stepped != 8'd0);
            end
            press_cnt_nxt = 16'd0;
          end
        end
      end
      CMD_SET_LEVEL: begin
        level_nxt = value;
        lamp_nxt  = (value != 8'd0);
      end
      CMD_SET_ON: begin
        lamp_nxt = (value != 8'd0) && (level_r != 8'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LEVEL_MAX;
      lamp_r      <= 1'b1;
      status_r    <= 1'b1;
      deb_r       <= 1'b0;
      deb_cnt_r   <= 16'd0;
      press_cnt_r <= 16'd0;
      blink_cnt_r <= 10'd0;
      blink_r     <= 1'b0;
    end else if (step_en) begin
      level_r     <= level_nxt;
      lamp_r      <= lamp_nxt;
      status_r    <= status_nxt;
      deb_r       <= deb_nxt;
      deb_cnt_r   <= deb_cnt_nxt;
      press_cnt_r <= press_cnt_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      blink_r     <= blink_nxt;
    end
  end

  always_comb begin
    stat.drive         = lamp_nxt ? level_nxt : 8'd0;
    stat.light_on      = lamp_nxt;
    stat.level         = level_nxt;
    stat.run_led       = status_nxt & blink_nxt;
    stat.status_active = status_nxt;
    stat.press_event   = ev;
  end

endmodule

`default_nettype wire

[hw/rtl/button_press_dimmer_control.sv]
// Top level of the button press dimmer control block.
// Depends on bpdc_pkg and bpdc_ctrl; holds the config registers and the request pipeline.
//
// One result per request, one request per cycle sustained while out_stall is low. A request
// passes an input register, the control-state update, the pulse-width multiply and the
// divide by 255, each registered; the result is offered from the last register. Each stage
// holds while the next one is full and stalled. Configuration writes are always ready
// and are meant to be made while no request is in flight.
`default_nettype none

module button_press_dimmer_control
  import bpdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic        in_button_raw,
  input  wire logic [7:0]  in_value,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_led_pulse,
  output logic [9:0]       out_inverted_pulse,
  output logic             out_light_on,
  output logic [7:0]       out_current_brightness,
  output logic             out_run_led,
  output logic             out_status_active,
  output logic [1:0]       out_press_event,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t        cfg_r;
  logic        v0_r, v1_r, v2_r, v3_r;
  logic        rdy0, rdy1, rdy2, rdy3;
  logic [1:0]  cmd_r;
  logic        raw_r;
  logic [7:0]  val_r;
  stat_t       stat_nxt;
  stat_t       s1_r, s2_r, s3_r;
  logic [17:0] led_prod_r, inv_prod_r;
  logic [9:0]  led_pulse_r, inv_pulse_r;
  logic [7:0]  inv_drive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms     <= TICK_MS_RST;
      cfg_r.debounce_ms <= DEBOUNCE_MS_RST;
      cfg_r.medium_ms   <= MEDIUM_MS_RST;
      cfg_r.long_ms     <= LONG_MS_RST;
      cfg_r.period_us   <= PERIOD_US_RST;
      cfg_r.blink_ticks <= BLINK_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TICK_MS:     cfg_r.tick_ms     <= cfg_data[9:0];
        REG_DEBOUNCE_MS: cfg_r.debounce_ms <= cfg_data;
        REG_MEDIUM_MS:   cfg_r.medium_ms   <= cfg_data;
        REG_LONG_MS:     cfg_r.long_ms     <= cfg_data;
        REG_PERIOD_US:   cfg_r.period_us   <= cfg_data[9:0];
        REG_BLINK_TICKS: cfg_r.blink_ticks <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      cmd_r <= in_command;
      raw_r <= in_button_raw;
      val_r <= in_value;
    end
  end

  bpdc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (v0_r && rdy1),
    .command    (cmd_r),
    .button_raw (raw_r),
    .value      (val_r),
    .cfg        (cfg_r),
    .stat       (stat_nxt)
  );

  assign inv_drive = LEVEL_MAX - s1_r.drive;

  always_ff @(posedge clk) begin
    if (v0_r && rdy1) begin
      s1_r <= stat_nxt;
    end
    if (v1_r && rdy2) begin
      s2_r       <= s1_r;
      led_prod_r <= {10'b0, s1_r.drive} * {8'b0, cfg_r.period_us};
      inv_prod_r <= {10'b0, inv_drive} * {8'b0, cfg_r.period_us};
    end
    if (v2_r && rdy3) begin
      s3_r        <= s2_r;
      led_pulse_r <= div255(led_prod_r);
      inv_pulse_r <= div255(inv_prod_r);
    end
  end

  assign out_valid              = v3_r;
  assign out_led_pulse          = led_pulse_r;
  assign out_inverted_pulse     = inv_pulse_r;
  assign out_light_on           = s3_r.light_on;
  assign out_current_brightness = s3_r.level;
  assign out_run_led            = s3_r.run_led;
  assign out_status_active      = s3_r.status_active;
  assign out_press_event        = 2'(s3_r.press_event);

endmodule

`default_nettype wire

[tb/tb_button_press_dimmer_control.sv]
// Self-checking testbench for button_press_dimmer_control: button ticks, level and on/off
// requests are checked against a built-in predictor of the dimmer, debounce and blinker.
// Depends on bpdc_pkg and the button_press_dimmer_control RTL.
`timescale 1ns / 100ps

module tb_button_press_dimmer_control
  import bpdc_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [9:0] led_pulse;
    logic [9:0] inv_pulse;
    logic       light_on;
    logic [7:0] level;
    logic       run_led;
    logic       status;
    press_ev_t  ev;
  } lamp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_TICK;
  logic        in_button_raw = 1'b0;
  logic [7:0]  in_value = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_led_pulse;
  logic [9:0]  out_inverted_pulse;
  logic        out_light_on;
  logic [7:0]  out_current_brightness;
  logic        out_run_led;
  logic        out_status_active;
  logic [1:0]  out_press_event;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_TICK_MS;
  logic [15:0] cfg_data = 16'd0;

  // predictor copy of the settings
  logic [9:0]  tick_ms = TICK_MS_RST;
  logic [15:0] db_limit = DEBOUNCE_MS_RST;
  logic [15:0] medium_ms = MEDIUM_MS_RST;
  logic [15:0] long_ms = LONG_MS_RST;
  logic [9:0]  period_us = PERIOD_US_RST;
  logic [9:0]  blink_len = BLINK_TICKS_RST;

  // predictor copy of the dimmer state
  logic [7:0]  lvl = LEVEL_MAX;
  logic        lamp = 1'b1;
  logic        status_en = 1'b1;
  logic        btn_state = 1'b0;
  logic [15:0] db_ms = 16'd0;
  logic [15:0] hold_ms = 16'd0;
  logic [9:0]  blink_cnt = 10'd0;
  logic        blink_led = 1'b0;

  lamp_result_t lamp_expected[$];
  int mismatches = 0;
  int requests_sent = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  logic [7:0] hold_tag = 8'd0;
  logic [7:0] hold_seen = 8'd0;
  int hold_left = 0;

  button_press_dimmer_control u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_button_raw          (in_button_raw),
    .in_value               (in_value),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_led_pulse          (out_led_pulse),
    .out_inverted_pulse     (out_inverted_pulse),
    .out_light_on           (out_light_on),
    .out_current_brightness (out_current_brightness),
    .out_run_led            (out_run_led),
    .out_status_active      (out_status_active),
    .out_press_event        (out_press_event),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] sat_ms(input logic [15:0] acc, input logic [9:0] inc);
    logic [16:0] sum;
    sum = {1'b0, acc} + {7'b0, inc};
    return (sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : sum[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic predict_lamp(input logic [1:0] cmd, input logic raw, input logic [7:0] val);
    lamp_result_t r;
    int lim;
    int step;
    int drive;
    r.ev = EV_NONE;
    case (cmd)
      CMD_TICK: begin
        lim = (blink_len == 10'd0) ? 1 : int'(blink_len);
        if (status_en) begin
          if (blink_cnt == 10'd0) blink_led = ~blink_led;
          blink_cnt = (int'(blink_cnt) + 1 >= lim) ? 10'd0 : blink_cnt + 10'd1;
        end
        db_ms = (raw != btn_state) ? sat_ms(db_ms, tick_ms) : 16'd0;
        if (btn_state) hold_ms = sat_ms(hold_ms, tick_ms);
        if (db_ms > db_limit) begin
          btn_state = raw;
          if (!raw) begin
            if (hold_ms > long_ms) begin
              r.ev = EV_LONG;
            end else if (hold_ms > medium_ms) begin
              r.ev = EV_MEDIUM;
              status_en = ~status_en;
            end else begin
              step = (int'(lvl) / int'(LEVEL_STEP)) * int'(LEVEL_STEP);
              r.ev = EV_SHORT;
              lvl = (step == int'(LEVEL_MAX)) ? 8'd0 : 8'(step + int'(LEVEL_STEP));
              lamp = (lvl != 8'd0);
            end
            hold_ms = 16'd0;
          end
        end
      end
      CMD_SET_LEVEL: begin
        lvl = val;
        lamp = (val != 8'd0);
      end
      CMD_SET_ON: lamp = (val != 8'd0) && (lvl != 8'd0);
      default: ;
    endcase
    drive = lamp ? int'(lvl) : 0;
    r.led_pulse = 10'(drive * int'(period_us) / int'(LEVEL_MAX));
    r.inv_pulse = 10'((int'(LEVEL_MAX) - drive) * int'(period_us) / int'(LEVEL_MAX));
    r.light_on = lamp;
    r.level = lvl;
    r.run_led = status_en & blink_led;
    r.status = status_en;
    lamp_expected.push_back(r);
  endtask

  task automatic check_lamp_result();
    lamp_result_t want;
    if (lamp_expected.size() == 0) begin
      report_mismatch("unrequested result", 16'(out_current_brightness), 16'd0);
      return;
    end
    want = lamp_expected.pop_front();
    if (out_led_pulse !== want.led_pulse)
      report_mismatch("led_pulse", 16'(out_led_pulse), 16'(want.led_pulse));
    if (out_inverted_pulse !== want.inv_pulse)
      report_mismatch("inverted_pulse", 16'(out_inverted_pulse), 16'(want.inv_pulse));
    if (out_light_on !== want.light_on)
      report_mismatch("light_on", 16'(out_light_on), 16'(want.light_on));
    if (out_current_brightness !== want.level)
      report_mismatch("current_brightness", 16'(out_current_brightness),
                      16'(want.level));
    if (out_run_led !== want.run_led)
      report_mismatch("run_led", 16'(out_run_led), 16'(want.run_led));
    if (out_status_active !== want.status)
      report_mismatch("status_active", 16'(out_status_active), 16'(want.status));
    if (out_press_event !== want.ev)
      report_mismatch("press_event", 16'(out_press_event), 16'(want.ev));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_lamp_result();
    end
  end

  // result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic raw, input logic [7:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_button_raw <= raw;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_lamp(cmd, raw, val);
    requests_sent++;
  endtask

  task automatic press_button(input int down_ticks, input int up_ticks, input int bounce_pct);
    int k;
    for (k = 0; k < down_ticks; k++)
      send_request(CMD_TICK, !($urandom_range(99) < bounce_pct), 8'($urandom));
    for (k = 0; k < up_ticks; k++)
      send_request(CMD_TICK, ($urandom_range(99) < bounce_pct), 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (lamp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input cfg_reg_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TICK_MS:     tick_ms = data[9:0];
      REG_DEBOUNCE_MS: db_limit = data;
      REG_MEDIUM_MS:   medium_ms = data;
      REG_LONG_MS:     long_ms = data;
      REG_PERIOD_US:   period_us = data[9:0];
      REG_BLINK_TICKS: blink_len = data[9:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [9:0] t_ms, input logic [15:0] d_ms,
                               input logic [15:0] m_ms, input logic [15:0] l_ms,
                               input logic [9:0] p_us, input logic [9:0] b_ticks);
    wait_idle();
    write_setting(REG_TICK_MS, {6'b0, t_ms});
    write_setting(REG_DEBOUNCE_MS, d_ms);
    write_setting(REG_MEDIUM_MS, m_ms);
    write_setting(REG_LONG_MS, l_ms);
    write_setting(REG_PERIOD_US, {6'b0, p_us});
    write_setting(REG_BLINK_TICKS, {6'b0, b_ticks});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_gap_pct = 0;
    send_request(CMD_SET_ON, 1'b0, 8'd1);
    send_request(CMD_TICK, 1'b0, 8'hFF);
    // one tick of 1000 ms flips the debounced state; press time is whole ticks
    load_settings(10'd1000, 16'd0, 16'd2000, 16'd5000, 10'd40, 10'd2);
    send_request(CMD_SET_LEVEL, 1'b0, 8'd0);
    send_request(CMD_SET_ON, 1'b1, 8'd255);
    send_request(CMD_SET_LEVEL, 1'b1, 8'd255);
    send_request(CMD_SET_ON, 1'b0, 8'd0);
    send_request(CMD_SET_ON, 1'b0, 8'd1);
    send_request(CMD_UNUSED, 1'b1, 8'hAA);
    send_request(CMD_SET_LEVEL, 1'b0, 8'd170);
    press_button(1, 1, 0);
    press_button(1, 1, 0);
    press_button(3, 1, 0);
    send_request(CMD_TICK, 1'b0, 8'h55);
    press_button(3, 1, 0);
    press_button(6, 1, 0);
    send_request(CMD_SET_LEVEL, 1'b1, 8'd1);
  endtask

  task automatic test_timer_saturation();
    send_gap_pct = 0;
    load_settings(10'd1000, 16'd0, 16'd60000, 16'd60000, 10'd1000, 10'd1000);
    press_button(68, 1, 0);
  endtask

  task automatic test_mixed_traffic(input int gap, input int stall, input int n_items);
    int first;
    int pick;
    send_gap_pct = gap;
    stall_pct <= stall;
    first = requests_sent;
    while (requests_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        press_button($urandom_range(1, 14), $urandom_range(1, 10),
                     ($urandom_range(3) == 0) ? 15 : 0);
      end else if (pick < 85) begin
        send_request(CMD_SET_LEVEL, 1'($urandom),
                     ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom));
      end else if (pick < 93) begin
        send_request(CMD_SET_ON, 1'($urandom),
                     ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom));
      end else if (pick < 96) begin
        send_request(CMD_UNUSED, 1'($urandom), 8'($urandom));
      end else begin
        send_request(CMD_TICK, 1'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_receiver_hold_off();
    int k;
    send_gap_pct = 0;
    stall_pct <= 0;
    hold_tag <= hold_tag + 8'd1;
    press_button(10, 6, 0);
    for (k = 0; k < 8; k++)
      send_request(CMD_SET_LEVEL, 1'($urandom), 8'($urandom));
  endtask

  initial begin
    int t;
    int m;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_timer_saturation();
    load_settings(10'd1, 16'd2, 16'd6, 16'd12, 10'd1000, 10'd0);
    test_mixed_traffic(0, 0, 85);
    load_settings(10'd1000, 16'd0, 16'd0, 16'd0, 10'd1, 10'd1);
    test_mixed_traffic(59, 0, 85);
    load_settings(10'd333, 16'd600, 16'd1500, 16'd3000, 10'd0, 10'd3);
    test_mixed_traffic(0, 59, 85);
    t = $urandom_range(1, 1000);
    m = t * $urandom_range(1, 5);
    load_settings(10'(t), 16'(t * $urandom_range(0, 2)), 16'(m),
                  16'(m + t * $urandom_range(1, 5)),
                  10'($urandom_range(0, 1000)), 10'($urandom_range(1, 1000)));
    test_mixed_traffic(23, 23, 85);
    test_receiver_hold_off();
    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
